### sv/asp_pkg.sv
// ----------------------------------------------------------------------------
// asp_pkg: shared types and codes of the archive stream parser
// Stream word layouts, record kinds, error codes and the signature bytes.
// ----------------------------------------------------------------------------
package asp_pkg;

    // One input word: a raw archive byte and the restart flag
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_req;
    } in_word_t;

    // One result word
    typedef struct packed {
        logic [3:0]  record_kind;
        logic [31:0] first_value;
        logic [31:0] second_value;
        logic [2:0]  property_kind;
        logic [1:0]  error_code;
        logic        archive_end;
    } out_word_t;

    // Status of the varint step
    typedef struct packed {
        logic complete;   // byte had bit 7 clear, value finished
        logic overlong;   // continuation on the last allowed byte
    } varint_status_t;

    // Record kinds
    localparam logic [3:0] KIND_VERSION    = 4'd0;
    localparam logic [3:0] KIND_ATOM_COUNT = 4'd1;
    localparam logic [3:0] KIND_ATOM_CHAR  = 4'd2;
    localparam logic [3:0] KIND_ATOM_END   = 4'd3;
    localparam logic [3:0] KIND_EXPR_COUNT = 4'd4;
    localparam logic [3:0] KIND_EXPR       = 4'd5;
    localparam logic [3:0] KIND_NODE_COUNT = 4'd6;
    localparam logic [3:0] KIND_PROP_COUNT = 4'd7;
    localparam logic [3:0] KIND_PROPERTY   = 4'd8;
    localparam logic [3:0] KIND_ERROR      = 4'd9;

    // Error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_SIGNATURE = 2'd1;
    localparam logic [1:0] ERR_VERSION   = 2'd2;
    localparam logic [1:0] ERR_OVERLONG  = 2'd3;

    // Configuration register indexes
    localparam logic CFG_EXPECTED_VERSION = 1'b0;
    localparam logic CFG_VERSION_AGE      = 1'b1;

    // Signature "GARC"
    localparam logic [7:0] SIG_BYTE [4] = '{8'h47, 8'h41, 8'h52, 8'h43};

    localparam logic [7:0] VARINT_PAYLOAD_MASK = 8'h7f;
    localparam int         VARINT_CONT_BIT     = 7;
    localparam int         PROP_KIND_BITS      = 3;

endpackage

### sv/archive_stream_parser_core.sv
// ----------------------------------------------------------------------------
// archive_stream_parser_core: byte-serial archive container parser
// Checks the signature, decodes varint fields and emits one record per field.
// ----------------------------------------------------------------------------
// The parser takes one archive byte per clock cycle while in_stall is low:
// the whole state update for a byte (signature compare, one varint merge
// step, a counter decrement and the phase change) closes within the cycle
// in which the byte is accepted, and the record it produces is loaded into
// the output register as the byte is accepted. The output register decouples
// the two sides, so in_stall rises only while a finished record is held by
// out_stall. Set start_req on the first byte of each archive; after an
// error or at the end of an archive, bytes without start_req are swallowed
// silently. Varints longer than (VALUE_BITS+6)/7 bytes are reported as
// errors and payload bits above VALUE_BITS are dropped. Record values are
// 32 bits wide on the port. Configuration (index 0: newest version,
// index 1: version age) is always ready and should only be written while
// the parser is idle.
// ----------------------------------------------------------------------------
module archive_stream_parser_core #(
    parameter int VALUE_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    // byte stream in
    input  logic                in_valid,
    output logic                in_stall,
    input  asp_pkg::in_word_t   in_word,
    // record stream out
    output logic                out_valid,
    input  logic                out_stall,
    output asp_pkg::out_word_t  out_word,
    // configuration writes
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_data
);

    localparam int MAX_BYTES = (VALUE_BITS + 6) / 7;
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);
    // compare width wide enough for both the value and the 32-bit window
    localparam int CMP_W     = (VALUE_BITS > 32) ? VALUE_BITS : 32;

    // parse phases
    localparam logic [3:0] PH_SIG        = 4'd0;
    localparam logic [3:0] PH_VERSION    = 4'd1;
    localparam logic [3:0] PH_ATOM_COUNT = 4'd2;
    localparam logic [3:0] PH_ATOM_CHAR  = 4'd3;
    localparam logic [3:0] PH_EXPR_COUNT = 4'd4;
    localparam logic [3:0] PH_EXPR_NAME  = 4'd5;
    localparam logic [3:0] PH_EXPR_ROOT  = 4'd6;
    localparam logic [3:0] PH_NODE_COUNT = 4'd7;
    localparam logic [3:0] PH_PROP_COUNT = 4'd8;
    localparam logic [3:0] PH_PROP_NAME  = 4'd9;
    localparam logic [3:0] PH_PROP_VALUE = 4'd10;
    localparam logic [3:0] PH_DONE       = 4'd11;
    localparam logic [3:0] PH_HALT       = 4'd12;

    // configuration
    logic [31:0] expected_version_reg;
    logic [31:0] version_age_reg;

    // parse state
    logic [3:0]            phase_reg,  phase_next;
    logic [1:0]            sig_pos_reg, sig_pos_next;
    logic [VALUE_BITS-1:0] acc_reg,    acc_next;
    logic [CNT_W-1:0]      cnt_reg,    cnt_next;
    logic [VALUE_BITS-1:0] items_reg,  items_next;
    logic [VALUE_BITS-1:0] nodes_reg,  nodes_next;
    logic [VALUE_BITS-1:0] props_reg,  props_next;
    logic [VALUE_BITS-1:0] held_reg,   held_next;

    // output register
    logic                  out_valid_reg;
    asp_pkg::out_word_t    out_word_reg;

    // state as seen by the current byte (start_req clears it first)
    logic [3:0]            cur_phase;
    logic [1:0]            cur_sig_pos;
    logic [VALUE_BITS-1:0] cur_acc;
    logic [CNT_W-1:0]      cur_cnt;
    logic [VALUE_BITS-1:0] cur_items;
    logic [VALUE_BITS-1:0] cur_nodes;
    logic [VALUE_BITS-1:0] cur_props;
    logic [VALUE_BITS-1:0] cur_held;

    logic                  take;
    logic [7:0]            byte_in;
    logic                  emit;
    asp_pkg::out_word_t    rec;

    // varint step
    logic [VALUE_BITS-1:0]   v_value;
    logic [CNT_W-1:0]        v_cnt_inc;
    asp_pkg::varint_status_t v_stat;

    // derived values
    logic [CMP_W-1:0]      v_wide;
    logic [CMP_W-1:0]      held_wide;
    logic [CMP_W-1:0]      held_name_wide;
    logic [CMP_W-1:0]      exp_wide;
    logic [CMP_W-1:0]      lo_wide;
    logic [31:0]           lo_bound;
    logic [VALUE_BITS-1:0] items_dec;
    logic [VALUE_BITS-1:0] nodes_dec;
    logic [VALUE_BITS-1:0] props_dec;
    logic                  items_last;
    logic                  nodes_last;
    logic                  props_last;

    assign take      = in_valid && !in_stall;
    assign in_stall  = out_valid_reg && out_stall;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign cfg_ready = 1'b1;
    assign byte_in   = in_word.data_byte;

    assign cur_phase   = in_word.start_req ? PH_SIG : phase_reg;
    assign cur_sig_pos = in_word.start_req ? 2'd0 : sig_pos_reg;
    assign cur_acc     = in_word.start_req ? '0 : acc_reg;
    assign cur_cnt     = in_word.start_req ? '0 : cnt_reg;
    assign cur_items   = in_word.start_req ? '0 : items_reg;
    assign cur_nodes   = in_word.start_req ? '0 : nodes_reg;
    assign cur_props   = in_word.start_req ? '0 : props_reg;
    assign cur_held    = in_word.start_req ? '0 : held_reg;

    asp_varint #(
        .VALUE_BITS (VALUE_BITS),
        .CNT_W      (CNT_W)
    ) u_varint (
        .acc       (cur_acc),
        .cnt       (cur_cnt),
        .data_byte (byte_in),
        .merged    (v_value),
        .cnt_inc   (v_cnt_inc),
        .status    (v_stat)
    );

    // counters stop at zero; "last" means the count reaches zero now
    assign items_dec  = cur_items - VALUE_BITS'(cur_items != '0);
    assign nodes_dec  = cur_nodes - VALUE_BITS'(cur_nodes != '0);
    assign props_dec  = cur_props - VALUE_BITS'(cur_props != '0);
    assign items_last = (items_dec == '0);
    assign nodes_last = (nodes_dec == '0);
    assign props_last = (props_dec == '0);

    assign v_wide         = CMP_W'(v_value);
    assign held_wide      = CMP_W'(cur_held);
    assign held_name_wide = CMP_W'(cur_held >> asp_pkg::PROP_KIND_BITS);

    // version window, lower bound saturating at zero
    assign lo_bound = (version_age_reg > expected_version_reg)
                      ? 32'd0 : (expected_version_reg - version_age_reg);
    assign exp_wide = CMP_W'(expected_version_reg);
    assign lo_wide  = CMP_W'(lo_bound);

    always_comb
    begin
        phase_next   = cur_phase;
        sig_pos_next = cur_sig_pos;
        acc_next     = cur_acc;
        cnt_next     = cur_cnt;
        items_next   = cur_items;
        nodes_next   = cur_nodes;
        props_next   = cur_props;
        held_next    = cur_held;
        emit         = 1'b0;
        rec          = '0;

        unique case (cur_phase)
            PH_SIG:
            begin
                if (byte_in != asp_pkg::SIG_BYTE[cur_sig_pos]) begin
                    phase_next         = PH_HALT;
                    emit               = 1'b1;
                    rec.record_kind    = asp_pkg::KIND_ERROR;
                    rec.first_value    = 32'(byte_in);
                    rec.error_code     = asp_pkg::ERR_SIGNATURE;
                end else begin
                    sig_pos_next = cur_sig_pos + 2'd1;
                    if (cur_sig_pos == 2'd3) begin
                        phase_next = PH_VERSION;
                    end
                end
            end

            PH_ATOM_CHAR:
            begin
                emit = 1'b1;
                if (byte_in != 8'd0) begin
                    rec.record_kind = asp_pkg::KIND_ATOM_CHAR;
                    rec.first_value = 32'(byte_in);
                end else begin
                    items_next      = items_dec;
                    rec.record_kind = asp_pkg::KIND_ATOM_END;
                    if (items_last) begin
                        phase_next = PH_EXPR_COUNT;
                    end
                end
            end

            PH_DONE, PH_HALT:
            begin
                // swallow bytes until the next start
            end

            PH_VERSION, PH_ATOM_COUNT, PH_EXPR_COUNT, PH_EXPR_NAME, PH_EXPR_ROOT,
            PH_NODE_COUNT, PH_PROP_COUNT, PH_PROP_NAME, PH_PROP_VALUE:
            begin
                if (!v_stat.complete) begin
                    acc_next = v_value;
                    cnt_next = v_cnt_inc;
                    if (v_stat.overlong) begin
                        phase_next      = PH_HALT;
                        emit            = 1'b1;
                        rec.record_kind = asp_pkg::KIND_ERROR;
                        rec.error_code  = asp_pkg::ERR_OVERLONG;
                    end
                end else begin
                    acc_next        = '0;
                    cnt_next        = '0;
                    rec.first_value = v_wide[31:0];
                    unique case (cur_phase)
                        PH_VERSION:
                        begin
                            emit = 1'b1;
                            if (v_wide > exp_wide || v_wide < lo_wide) begin
                                phase_next      = PH_HALT;
                                rec.record_kind = asp_pkg::KIND_ERROR;
                                rec.error_code  = asp_pkg::ERR_VERSION;
                            end else begin
                                phase_next      = PH_ATOM_COUNT;
                                rec.record_kind = asp_pkg::KIND_VERSION;
                            end
                        end
                        PH_ATOM_COUNT:
                        begin
                            emit            = 1'b1;
                            items_next      = v_value;
                            phase_next      = (v_value == '0) ? PH_EXPR_COUNT : PH_ATOM_CHAR;
                            rec.record_kind = asp_pkg::KIND_ATOM_COUNT;
                        end
                        PH_EXPR_COUNT:
                        begin
                            emit            = 1'b1;
                            items_next      = v_value;
                            phase_next      = (v_value == '0) ? PH_NODE_COUNT : PH_EXPR_NAME;
                            rec.record_kind = asp_pkg::KIND_EXPR_COUNT;
                        end
                        PH_EXPR_NAME:
                        begin
                            held_next  = v_value;
                            phase_next = PH_EXPR_ROOT;
                        end
                        PH_EXPR_ROOT:
                        begin
                            emit             = 1'b1;
                            items_next       = items_dec;
                            phase_next       = items_last ? PH_NODE_COUNT : PH_EXPR_NAME;
                            rec.record_kind  = asp_pkg::KIND_EXPR;
                            rec.first_value  = held_wide[31:0];
                            rec.second_value = v_wide[31:0];
                        end
                        PH_NODE_COUNT:
                        begin
                            emit            = 1'b1;
                            nodes_next      = v_value;
                            rec.record_kind = asp_pkg::KIND_NODE_COUNT;
                            if (v_value == '0) begin
                                phase_next      = PH_DONE;
                                rec.archive_end = 1'b1;
                            end else begin
                                phase_next = PH_PROP_COUNT;
                            end
                        end
                        PH_PROP_COUNT:
                        begin
                            emit            = 1'b1;
                            props_next      = v_value;
                            rec.record_kind = asp_pkg::KIND_PROP_COUNT;
                            if (v_value == '0) begin
                                // empty node closes right away
                                nodes_next      = nodes_dec;
                                phase_next      = nodes_last ? PH_DONE : PH_PROP_COUNT;
                                rec.archive_end = nodes_last;
                            end else begin
                                phase_next = PH_PROP_NAME;
                            end
                        end
                        PH_PROP_NAME:
                        begin
                            held_next  = v_value;
                            phase_next = PH_PROP_VALUE;
                        end
                        PH_PROP_VALUE:
                        begin
                            emit              = 1'b1;
                            props_next        = props_dec;
                            rec.record_kind   = asp_pkg::KIND_PROPERTY;
                            rec.first_value   = held_name_wide[31:0];
                            rec.second_value  = v_wide[31:0];
                            rec.property_kind = cur_held[asp_pkg::PROP_KIND_BITS-1:0];
                            if (props_last) begin
                                nodes_next      = nodes_dec;
                                phase_next      = nodes_last ? PH_DONE : PH_PROP_COUNT;
                                rec.archive_end = nodes_last;
                            end else begin
                                phase_next = PH_PROP_NAME;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_HALT;
                        end
                    endcase
                end
            end

            default:
            begin
                // unused phase code
                phase_next = PH_HALT;
            end
        endcase
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg   <= PH_SIG;
            sig_pos_reg <= 2'd0;
            acc_reg     <= '0;
            cnt_reg     <= '0;
            items_reg   <= '0;
            nodes_reg   <= '0;
            props_reg   <= '0;
            held_reg    <= '0;
        end else if (take) begin
            phase_reg   <= phase_next;
            sig_pos_reg <= sig_pos_next;
            acc_reg     <= acc_next;
            cnt_reg     <= cnt_next;
            items_reg   <= items_next;
            nodes_reg   <= nodes_next;
            props_reg   <= props_next;
            held_reg    <= held_next;
        end
    end

    // output register: loads on every accepted byte, drains when not stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (take) begin
            out_valid_reg <= emit;
        end else if (!out_stall) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit) begin
            out_word_reg <= rec;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            expected_version_reg <= 32'd1;
            version_age_reg      <= 32'd0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                asp_pkg::CFG_EXPECTED_VERSION: expected_version_reg <= cfg_data;
                asp_pkg::CFG_VERSION_AGE:      version_age_reg      <= cfg_data;
                default:                       ;
            endcase
        end
    end

endmodule

### sv/asp_varint.sv
// ----------------------------------------------------------------------------
// asp_varint: one step of the little-endian base-128 decoder
// Merges the 7 payload bits of a byte into the running value and flags
// completion or an overlong encoding.
// ----------------------------------------------------------------------------
module asp_varint #(
    parameter int VALUE_BITS = 32,
    parameter int CNT_W      = 3
) (
    input  logic [VALUE_BITS-1:0]   acc,
    input  logic [CNT_W-1:0]        cnt,
    input  logic [7:0]              data_byte,
    output logic [VALUE_BITS-1:0]   merged,
    output logic [CNT_W-1:0]        cnt_inc,
    output asp_pkg::varint_status_t status
);

    localparam int MAX_BYTES = (VALUE_BITS + 6) / 7;
    localparam int SH_W      = $clog2(7 * MAX_BYTES);

    logic [SH_W-1:0]       shift_amt;
    logic [VALUE_BITS-1:0] payload;

    // bits shifted past VALUE_BITS fall off the top
    assign shift_amt = SH_W'(32'(cnt) * 32'd7);
    assign payload   = VALUE_BITS'(data_byte & asp_pkg::VARINT_PAYLOAD_MASK);
    assign merged    = acc | (payload << shift_amt);
    assign cnt_inc   = cnt + CNT_W'(1);

    assign status.complete = ~data_byte[asp_pkg::VARINT_CONT_BIT];
    assign status.overlong = data_byte[asp_pkg::VARINT_CONT_BIT]
                             && (cnt_inc >= CNT_W'(MAX_BYTES));

endmodule

### sv/asp_checker.sv
// ----------------------------------------------------------------------------
// asp_checker: port-level checks for the archive stream parser
// Watches the stream ports and the fields of emitted records.
// ----------------------------------------------------------------------------
module asp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input asp_pkg::out_word_t out_word
);

    // input only backs up behind a held record
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("in_stall without a pending record");

    // a stalled record is held unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("stalled record changed or dropped");

    // error records carry a code, a zero second value and property kind, and no archive end
    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.record_kind == asp_pkg::KIND_ERROR |->
            out_word.error_code != asp_pkg::ERR_NONE && out_word.second_value == 32'd0
            && out_word.property_kind == 3'd0 && !out_word.archive_end)
        else $error("malformed error record");

    // only error records carry an error code
    a_no_stray_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.record_kind != asp_pkg::KIND_ERROR |->
            out_word.error_code == asp_pkg::ERR_NONE)
        else $error("error code on a non-error record");

    // archive end only on node count, prop count or property records
    a_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.archive_end |->
            out_word.record_kind == asp_pkg::KIND_NODE_COUNT
            || out_word.record_kind == asp_pkg::KIND_PROP_COUNT
            || out_word.record_kind == asp_pkg::KIND_PROPERTY)
        else $error("archive end on wrong record kind");

endmodule

bind archive_stream_parser_core asp_checker u_asp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
);
